[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, quiet while reset is asserted.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/dssel_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssel_pkg
// Field widths, action codes, list entry types and the sigmoid table.
// ----------------------------------------------------------------------------
package dssel_pkg;

  localparam int ACT_W       = 2;
  localparam int IDX_W       = 8;
  localparam int VAL_W       = 16;
  localparam int PID_W       = 20;
  localparam int RANK_F_W    = 4;
  localparam int SCORE_W     = 17;
  localparam int VLEN_W      = 9;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 48;
  localparam int PROD_W      = 32;
  localparam int ACC_W       = 48;
  localparam int FRAC_W      = 24;
  localparam int SIG_LIMIT   = 10;
  localparam int ROM_DEPTH   = 2001;
  localparam int ROM_LAST    = 2000;
  localparam int ROM_AW      = 11;
  localparam int SPAN_W      = 29;
  localparam int SPAN_MUL    = 100;
  localparam int SPAN_PROD_W = 36;
  localparam int VLEN_RESET  = 256;

  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CAND  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FLUSH = 2'd2;

  localparam logic [SCORE_W-1:0] SCORE_ONE = 17'h10000;
  localparam logic signed [ACC_W-1:0] SUM_LIM = ACC_W'(SIG_LIMIT * (1 << FRAC_W));

  localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;

  typedef struct packed {
    logic               filled;
    logic [SCORE_W-1:0] score;
    logic [PID_W-1:0]   id;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } cell_op_t;

  typedef struct packed {
    logic ins;
    logic flush;
  } chain_cmd_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic busy;
  } chain_stat_t;

  // Shift-subtract quotient, evaluated at elaboration only.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    int          b;
    q = '0;
    r = '0;
    for (b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Entry i holds round(65536 / (1 + exp(-(i-1000)/100))); the top entry is 1.0.
  function automatic logic [ROM_DEPTH*SCORE_W-1:0] build_sig_table();
    logic [ROM_DEPTH*SCORE_W-1:0] tab;
    logic [63:0]                  term;
    logic [63:0]                  step;
    logic [63:0]                  e;
    logic [63:0]                  d;
    logic [63:0]                  s;
    logic [127:0]                 p;
    int                           k;
    int                           n;
    tab  = '0;
    term = ONE_Q62;
    step = ONE_Q62;
    e    = ONE_Q62;
    // exp(-1/100) by its series
    for (k = 1; k <= 12; k++) begin
      term = udiv64(term, 64'(100 * k));
      if (k[0]) begin
        step = step - term;
      end else begin
        step = step + term;
      end
    end
    for (n = 0; n <= 1000; n++) begin
      d = (ONE_Q62 + e) >> 20;
      s = udiv64((64'd1 << 58) + (d >> 1), d);
      tab[(1000 + n)*SCORE_W +: SCORE_W] = s[SCORE_W-1:0];
      tab[(1000 - n)*SCORE_W +: SCORE_W] = SCORE_ONE - s[SCORE_W-1:0];
      p = {64'd0, e} * {64'd0, step};
      e = p[125:62];
    end
    tab[ROM_LAST*SCORE_W +: SCORE_W] = SCORE_ONE;
    return tab;
  endfunction

  localparam logic [ROM_DEPTH*SCORE_W-1:0] SIG_TABLE = build_sig_table();

endpackage

[design/dssel_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssel_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dssel_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/dssel_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssel_cell
// One slot of the sorted list: holds, takes a new entry, or takes a neighbor.
// ----------------------------------------------------------------------------
module dssel_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  dssel_pkg::cell_op_t op,
  input  dssel_pkg::entry_t new_ent,
  input  dssel_pkg::entry_t left_ent,
  input  dssel_pkg::entry_t right_ent,
  input  logic              hit_in,
  output dssel_pkg::entry_t ent_o,
  output logic              hit_o
);
  import dssel_pkg::*;

  logic               filled_r;
  logic               filled_nxt;
  logic [SCORE_W-1:0] score_r;
  logic [SCORE_W-1:0] score_nxt;
  logic [PID_W-1:0]   id_r;
  logic [PID_W-1:0]   id_nxt;
  logic               take;

  assign ent_o = '{filled: filled_r, score: score_r, id: id_r};

  // ties keep the older entry: only a strictly better score takes the slot
  assign take  = !filled_r || (new_ent.score > score_r);
  assign hit_o = hit_in | take;

  always_comb begin
    filled_nxt = filled_r;
    score_nxt  = score_r;
    id_nxt     = id_r;
    if (op.shift) begin
      filled_nxt = right_ent.filled;
      score_nxt  = right_ent.score;
      id_nxt     = right_ent.id;
    end else if (op.ins) begin
      if (hit_in) begin
        filled_nxt = left_ent.filled;
        score_nxt  = left_ent.score;
        id_nxt     = left_ent.id;
      end else if (take) begin
        filled_nxt = 1'b1;
        score_nxt  = new_ent.score;
        id_nxt     = new_ent.id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= 1'b0;
    end else begin
      filled_r <= filled_nxt;
    end
  end

  always_ff @(posedge clk) begin
    score_r <= score_nxt;
    id_r    <= id_nxt;
  end

endmodule

[design/dssel_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssel_chain
// Row of list cells: sorted insert by all cells in parallel, unload through the head cell.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dssel_chain #(
  parameter int TOP_K  = 10,
  parameter int RANK_W = (TOP_K > 1) ? $clog2(TOP_K) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dssel_pkg::chain_cmd_t  cmd,
  input  dssel_pkg::entry_t      new_ent,
  input  logic                   out_ready,
  output dssel_pkg::chain_stat_t stat,
  output dssel_pkg::entry_t      head_ent,
  output logic [RANK_W-1:0]      rank_o
);
  import dssel_pkg::*;

  entry_t            ent_pad [TOP_K+1];
  logic              hit     [TOP_K+1];
  cell_op_t          op;
  logic              unload_r;
  logic              unload_nxt;
  logic [RANK_W-1:0] rank_r;
  logic [RANK_W-1:0] rank_nxt;
  logic              shift;
  logic              head_last;

  assign ent_pad[TOP_K] = '0;
  assign hit[0]         = 1'b0;

  assign head_last = !ent_pad[1].filled;
  assign stat.valid = unload_r && ent_pad[0].filled;
  assign stat.last  = head_last;
  assign stat.busy  = unload_r;
  assign head_ent   = ent_pad[0];
  assign rank_o     = rank_r;

  assign shift    = stat.valid && out_ready;
  assign op.shift = shift;
  assign op.ins   = cmd.ins;

  for (genvar k = 0; k < TOP_K; k++) begin : g_cell
    entry_t left_ent;
    if (k == 0) begin : g_head
      assign left_ent = '0;
    end else begin : g_body
      assign left_ent = ent_pad[k-1];
    end
    dssel_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .op        (op),
      .new_ent   (new_ent),
      .left_ent  (left_ent),
      .right_ent (ent_pad[k+1]),
      .hit_in    (hit[k]),
      .ent_o     (ent_pad[k]),
      .hit_o     (hit[k+1])
    );
  end

  always_comb begin
    unload_nxt = unload_r;
    rank_nxt   = rank_r;
    if (cmd.flush && ent_pad[0].filled) begin
      unload_nxt = 1'b1;
      rank_nxt   = '0;
    end else if (shift) begin
      rank_nxt = rank_r + RANK_W'(1);
      if (head_last) begin
        unload_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unload_r <= 1'b0;
      rank_r   <= '0;
    end else begin
      unload_r <= unload_nxt;
      rank_r   <= rank_nxt;
    end
  end

  // filled slots always form a prefix of the row
  for (genvar k = 1; k < TOP_K; k++) begin : g_chk
    `ASSERT_IMP(a_fill_prefix, clk, rst_n, ent_pad[k].filled, ent_pad[k-1].filled)
  end

  `ASSERT_IMP(a_no_cmd_unload, clk, rst_n, unload_r, !cmd.ins && !cmd.flush)
  `ASSERT_NXT(a_last_ends_unload, clk, rst_n, shift && head_last, !stat.valid)

endmodule

[design/dot_sigmoid_top_k_select_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dot_sigmoid_top_k_select_core
// Top-K dot-product search with a sigmoid score over streamed Q4.12 vectors.
// ----------------------------------------------------------------------------
// Query loads and candidate elements are taken one per cycle while in_tready is
// high; the candidate path is a five-stage pipeline (query store read, 16x16
// multiply, 48-bit accumulate, range check and table address, table read) and
// a candidate's score enters the list from stage 5 after its last element. The
// list is a row of TOP_K cells that sorts each insert by all cells in parallel.
// A flush waits for the pipeline to drain, then emits one list entry per cycle
// from the head cell while out_tready is high and no input is taken. After reset
// the 2001-entry sigmoid table is loaded into its RAM, one entry per cycle, so no
// input transaction is taken until the load ends; configuration writes are taken always.
`include "assert_macros.svh"

module dot_sigmoid_top_k_select_core #(
  parameter int VEC_MAX = 256,
  parameter int TOP_K   = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: vec_length
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // element_index[7:0], element_value[23:8], paper_id[43:24]
  input  logic [1:0]  in_tuser,   // action[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // rank[3:0], entry_paper[23:4], score[40:24]
  output logic        out_tlast   // last_of_list
);
  import dssel_pkg::*;

  localparam int QA_W   = (VEC_MAX > 1) ? $clog2(VEC_MAX) : 1;
  localparam int RANK_W = (TOP_K > 1) ? $clog2(TOP_K) : 1;

  // input fields
  logic [ACT_W-1:0]        in_action;
  logic [IDX_W-1:0]        in_idx;
  logic signed [VAL_W-1:0] in_val;
  logic [PID_W-1:0]        in_pid;
  logic                    in_fire;
  logic                    in_range;
  logic                    in_last;

  logic [VLEN_W-1:0] vlen_r;

  // sigmoid table load
  logic              fill_busy_r;
  logic [ROM_AW-1:0] fill_addr_r;

  // stage 1: query store read
  logic                    s1_cand_r, s1_flush_r;
  logic                    s1_first_r, s1_last_r, s1_range_r;
  logic signed [VAL_W-1:0] s1_val_r;
  logic [PID_W-1:0]        s1_pid_r;
  logic [VAL_W-1:0]        qram_rdata;
  logic signed [VAL_W-1:0] q_val;
  logic signed [PROD_W-1:0] s1_prod;

  // stage 2: multiply result
  logic                     s2_cand_r, s2_flush_r;
  logic                     s2_first_r, s2_last_r;
  logic signed [PROD_W-1:0] s2_prod_r;
  logic [PID_W-1:0]         s2_pid_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  acc_sum;

  // stage 3: finished sum
  logic                    s3_ins_r, s3_flush_r;
  logic signed [ACC_W-1:0] s3_sum_r;
  logic [PID_W-1:0]        s3_pid_r;

  // stage 4: table span
  logic              s4_ins_r, s4_flush_r, s4_hi_r, s4_lo_r;
  logic [SPAN_W-1:0] s4_span_r;
  logic [PID_W-1:0]  s4_pid_r;
  logic [SPAN_PROD_W-1:0] span_prod;
  logic [ROM_AW-1:0]      rom_raddr;

  // stage 5: table data
  logic               s5_ins_r, s5_flush_r, s5_hi_r, s5_lo_r;
  logic [PID_W-1:0]   s5_pid_r;
  logic [SCORE_W-1:0] rom_rdata;
  logic [SCORE_W-1:0] s5_score;

  // list
  chain_cmd_t        cmd;
  entry_t            new_ent;
  chain_stat_t       stat;
  entry_t            head_ent;
  logic [RANK_W-1:0] rank;
  logic              flush_pend;

  assign in_action = in_tuser[1:0];
  assign in_idx    = in_tdata[7:0];
  assign in_val    = $signed(in_tdata[23:8]);
  assign in_pid    = in_tdata[43:24];

  assign flush_pend = s1_flush_r | s2_flush_r | s3_flush_r | s4_flush_r | s5_flush_r;
  assign in_tready  = !fill_busy_r && !stat.busy && !flush_pend;
  assign in_fire    = in_tvalid && in_tready;
  assign in_range   = (32'(in_idx) < VEC_MAX);
  assign in_last    = (vlen_r != '0) && ({1'b0, in_idx} == (vlen_r - VLEN_W'(1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlen_r <= VLEN_W'(VLEN_RESET);
    end else if (cfg_we) begin
      vlen_r <= cfg_wdata;
    end
  end

  // ---- sigmoid table load after reset ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_busy_r <= 1'b1;
      fill_addr_r <= '0;
    end else if (fill_busy_r) begin
      fill_addr_r <= fill_addr_r + ROM_AW'(1);
      if (fill_addr_r == ROM_AW'(ROM_LAST)) begin
        fill_busy_r <= 1'b0;
      end
    end
  end

  dssel_ram #(
    .WIDTH (SCORE_W),
    .DEPTH (ROM_DEPTH),
    .AW    (ROM_AW)
  ) u_sig_ram (
    .clk   (clk),
    .we    (fill_busy_r),
    .waddr (fill_addr_r),
    .wdata (SIG_TABLE[fill_addr_r*SCORE_W +: SCORE_W]),
    .raddr (rom_raddr),
    .rdata (rom_rdata)
  );

  // ---- query store ----
  dssel_ram #(
    .WIDTH (VAL_W),
    .DEPTH (VEC_MAX),
    .AW    (QA_W)
  ) u_query_ram (
    .clk   (clk),
    .we    (in_fire && (in_action == ACT_LOAD) && in_range),
    .waddr (QA_W'(in_idx)),
    .wdata (in_tdata[23:8]),
    .raddr (QA_W'(in_idx)),
    .rdata (qram_rdata)
  );

  // ---- stage 1 ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_cand_r  <= 1'b0;
      s1_flush_r <= 1'b0;
    end else begin
      s1_cand_r  <= in_fire && (in_action == ACT_CAND);
      s1_flush_r <= in_fire && (in_action == ACT_FLUSH);
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= (in_idx == '0);
    s1_last_r  <= in_last;
    s1_range_r <= in_range;
    s1_val_r   <= in_val;
    s1_pid_r   <= in_pid;
  end

  assign q_val   = s1_range_r ? $signed(qram_rdata) : '0;
  assign s1_prod = q_val * s1_val_r;

  // ---- stage 2 ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_cand_r  <= 1'b0;
      s2_flush_r <= 1'b0;
    end else begin
      s2_cand_r  <= s1_cand_r;
      s2_flush_r <= s1_flush_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_prod_r  <= s1_prod;
    s2_pid_r   <= s1_pid_r;
  end

  // restart on index zero, clear after the last element
  assign acc_sum = (s2_first_r ? '0 : acc_r) + ACC_W'(s2_prod_r);

  always_comb begin
    acc_nxt = acc_r;
    if (s2_cand_r) begin
      acc_nxt = s2_last_r ? '0 : acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  // ---- stage 3 ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ins_r   <= 1'b0;
      s3_flush_r <= 1'b0;
    end else begin
      s3_ins_r   <= s2_cand_r && s2_last_r;
      s3_flush_r <= s2_flush_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_sum_r <= acc_sum;
    s3_pid_r <= s2_pid_r;
  end

  // ---- stage 4 ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_ins_r   <= 1'b0;
      s4_flush_r <= 1'b0;
    end else begin
      s4_ins_r   <= s3_ins_r;
      s4_flush_r <= s3_flush_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_hi_r   <= (s3_sum_r > SUM_LIM);
    s4_lo_r   <= (s3_sum_r < -SUM_LIM);
    s4_span_r <= SPAN_W'(s3_sum_r + SUM_LIM);
    s4_pid_r  <= s3_pid_r;
  end

  // floor((f + 10) * 100) with f in Q24.24
  assign span_prod = SPAN_PROD_W'(s4_span_r) * SPAN_PROD_W'(SPAN_MUL);
  assign rom_raddr = span_prod[FRAC_W +: ROM_AW];

  // ---- stage 5 ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_ins_r   <= 1'b0;
      s5_flush_r <= 1'b0;
    end else begin
      s5_ins_r   <= s4_ins_r;
      s5_flush_r <= s4_flush_r;
    end
  end

  always_ff @(posedge clk) begin
    s5_hi_r  <= s4_hi_r;
    s5_lo_r  <= s4_lo_r;
    s5_pid_r <= s4_pid_r;
  end

  assign s5_score = s5_hi_r ? SCORE_ONE : (s5_lo_r ? '0 : rom_rdata);

  // ---- sorted list ----
  assign cmd.ins   = s5_ins_r;
  assign cmd.flush = s5_flush_r;
  assign new_ent   = '{filled: 1'b1, score: s5_score, id: s5_pid_r};

  dssel_chain #(
    .TOP_K  (TOP_K),
    .RANK_W (RANK_W)
  ) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .new_ent   (new_ent),
    .out_ready (out_tready),
    .stat      (stat),
    .head_ent  (head_ent),
    .rank_o    (rank)
  );

  assign out_tvalid = stat.valid;
  assign out_tlast  = stat.last;
  assign out_tdata  = {7'd0, head_ent.score, head_ent.id, RANK_F_W'(rank)};

  `ASSERT_IMP(a_no_accept_unload, clk, rst_n, out_tvalid, !in_tready)
  `ASSERT_IMP(a_fill_quiet, clk, rst_n, fill_busy_r, !out_tvalid && !s5_ins_r)
  `ASSERT_NXT(a_flush_blocks, clk, rst_n, in_fire && (in_action == ACT_FLUSH), !in_tready)

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for dot_sigmoid_top_k_select_core. A directed table
// covers field extremes, the sigmoid saturation points, empty flushes and
// ignored actions. Random phases then stream query loads, candidate vectors
// and flushes under several vector lengths and handshake idling patterns.
// Flushed list entries are checked against an in-bench prediction of the dot
// product, sigmoid score and sorted top-K list, or against a directed row's entry.
// ----------------------------------------------------------------------------
module testbench;
  import dssel_pkg::*;

  localparam logic [ACT_W-1:0] ACT_IGNORED = 2'd3;
  localparam int LIST_SIZE      = 10;
  localparam int QUERY_DEPTH    = 256;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int SETTLE_CYCLES  = 24;
  localparam int NUM_PHASES     = 8;
  localparam int DIRECTED_ROWS  = 19;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] value;
    logic [PID_W-1:0] pid;
  } elem_t;

  typedef struct packed {
    logic [RANK_F_W-1:0] rank;
    logic [PID_W-1:0]    paper;
    logic [SCORE_W-1:0]  score;
    logic                last;
  } entry_result_t;

  typedef struct packed {
    elem_t         elem;
    logic          typed;    // expected entry given in the row itself
    logic          has_res;
    entry_result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [8:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // element_index[7:0], element_value[23:8], paper_id[43:24]
  logic [1:0]  in_tuser;   // action[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;  // rank[3:0], entry_paper[23:4], score[40:24]
  logic        out_tlast;  // last_of_list

  dot_sigmoid_top_k_select_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Predicted block state
  logic signed [VAL_W-1:0] query_mem [QUERY_DEPTH];
  bit                      query_written [QUERY_DEPTH];
  logic [ACC_W-1:0]        dot_sum;
  logic [SCORE_W-1:0]      best_score [LIST_SIZE];
  logic [PID_W-1:0]        best_id [LIST_SIZE];
  bit                      best_filled [LIST_SIZE];
  logic [VLEN_W-1:0]       vec_len;
  logic [SCORE_W-1:0]      sig_table [ROM_DEPTH];

  entry_result_t pending_entries [$];
  stim_row_t     directed_rows [DIRECTED_ROWS];

  int fail_count;
  int items_sent;
  int entries_checked;
  int idle_count;
  int send_idle_pct;
  int recv_stall_pct;

  int phase_vec   [NUM_PHASES] = '{1, 4, 13, 256, 0, 511, 8, 2};
  int phase_items [NUM_PHASES] = '{64, 64, 68, 54, 22, 22, 54, 52};
  int phase_send  [NUM_PHASES] = '{0, 54, 0, 13, 0, 54, 0, 13};
  int phase_recv  [NUM_PHASES] = '{0, 0, 54, 13, 0, 0, 54, 13};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Build round(65536 / (1 + exp(-x))) for x = -10.00 .. +10.00 in steps of 0.01
  function automatic void fill_sig_table();
    longint unsigned term;
    longint unsigned step;
    longint unsigned e;
    longint unsigned d;
    longint unsigned s;
    logic [127:0]    prod;
    term = ONE_Q62;
    step = ONE_Q62;
    e    = ONE_Q62;
    for (int k = 1; k <= 12; k++) begin
      term = term / 64'(100 * k);
      if (k % 2 == 1) begin
        step = step - term;
      end else begin
        step = step + term;
      end
    end
    for (int n = 0; n <= 1000; n++) begin
      d = (ONE_Q62 + e) >> 20;
      s = ((64'd1 << 58) + d / 2) / d;
      sig_table[1000 + n] = SCORE_W'(s);
      sig_table[1000 - n] = SCORE_W'(65536 - s);
      prod = 128'(e) * 128'(step);
      e    = prod[125:62];
    end
    sig_table[ROM_LAST] = SCORE_ONE;
  endfunction

  function automatic logic [SCORE_W-1:0] sigmoid_q16(input logic [ACC_W-1:0] sum);
    longint f;
    longint lim;
    f   = longint'($signed(sum));
    lim = longint'(SIG_LIMIT) << FRAC_W;
    if (f > lim) return SCORE_ONE;
    if (f < -lim) return '0;
    return sig_table[((f + lim) * 100) >> FRAC_W];
  endfunction

  // Ties keep the earlier entry; the tail entry drops out
  function automatic void insert_best(input logic [SCORE_W-1:0] sc, input logic [PID_W-1:0] id);
    for (int k = 0; k < LIST_SIZE; k++) begin
      if (!best_filled[k] || sc > best_score[k]) begin
        for (int j = LIST_SIZE - 1; j > k; j--) begin
          best_score[j]  = best_score[j-1];
          best_id[j]     = best_id[j-1];
          best_filled[j] = best_filled[j-1];
        end
        best_score[k]  = sc;
        best_id[k]     = id;
        best_filled[k] = 1'b1;
        return;
      end
    end
  endfunction

  function automatic void score_and_rank(input elem_t it, input bit keep);
    logic signed [31:0] prod;
    entry_result_t      r;
    case (it.action)
      ACT_LOAD: begin
        query_mem[it.idx]     = it.value;
        query_written[it.idx] = 1'b1;
      end
      ACT_CAND: begin
        prod    = query_mem[it.idx] * $signed(it.value);
        dot_sum = (it.idx == 0 ? '0 : dot_sum) + {{(ACC_W-32){prod[31]}}, prod};
        if (vec_len != 0 && {1'b0, it.idx} == vec_len - 1'b1) begin
          insert_best(sigmoid_q16(dot_sum), it.pid);
          dot_sum = '0;
        end
      end
      ACT_FLUSH: begin
        for (int k = 0; k < LIST_SIZE && best_filled[k]; k++) begin
          r.rank  = RANK_F_W'(k);
          r.paper = best_id[k];
          r.score = best_score[k];
          r.last  = (k + 1 >= LIST_SIZE) || !best_filled[k+1];
          if (keep) pending_entries.push_back(r);
        end
        for (int k = 0; k < LIST_SIZE; k++) begin
          best_score[k]  = '0;
          best_id[k]     = '0;
          best_filled[k] = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic elem_t mk_elem(input logic [ACT_W-1:0] act, input int idx,
                                    input logic [VAL_W-1:0] val, input logic [31:0] pid);
    elem_t it;
    it.action = act;
    it.idx    = IDX_W'(idx);
    it.value  = val;
    it.pid    = PID_W'(pid);
    return it;
  endfunction

  function automatic stim_row_t mk_row(input elem_t it, input bit typed, input bit has_res,
                                       input entry_result_t res);
    stim_row_t row;
    row.elem    = it;
    row.typed   = typed;
    row.has_res = has_res;
    row.res     = res;
    return row;
  endfunction

  // Mostly small Q4.12 values so that sums land inside the sigmoid's live range
  function automatic logic [VAL_W-1:0] rand_value();
    int s;
    case ($urandom_range(0, 7))
      0: return VAL_W'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0:       return 16'h7FFF;
          1:       return 16'h8000;
          2:       return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      default: begin
        s = int'($urandom_range(0, 4095)) - 2048;
        return VAL_W'(s);
      end
    endcase
  endfunction

  // Candidates only read query positions that hold a loaded element
  function automatic int pick_written(input int lo, input int hi);
    int i;
    repeat (16) begin
      i = $urandom_range(lo, hi);
      if (query_written[i]) return i;
    end
    for (i = lo; i <= hi; i++) begin
      if (query_written[i]) return i;
    end
    return 0;
  endfunction

  task automatic send_item(input elem_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.action;
    in_tdata  <= {4'b0, it.pid, it.value, it.idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (it.action != ACT_IGNORED) items_sent++;
  endtask

  task automatic issue(input elem_t it);
    send_item(it);
    score_and_rank(it, 1'b1);
  endtask

  task automatic send_candidate(input int len);
    int n_mid;
    if (len >= 1 && len <= QUERY_DEPTH) begin
      if (len > 1) issue(mk_elem(ACT_CAND, 0, rand_value(), $urandom));
      n_mid = (len > 2) ? $urandom_range(0, ((len - 2) < 6) ? (len - 2) : 6) : 0;
      repeat (n_mid) issue(mk_elem(ACT_CAND, pick_written(1, len - 2), rand_value(), $urandom));
      issue(mk_elem(ACT_CAND, len - 1, rand_value(), $urandom));
    end else begin
      // no element can close a vector at this length; just accumulate
      repeat ($urandom_range(1, 4))
        issue(mk_elem(ACT_CAND, pick_written(0, QUERY_DEPTH - 1), rand_value(), $urandom));
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk) begin : check_results
    entry_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_entries.size() == 0) begin
        $error("list entry with none expected: rank %0d paper %0h score %0d",
               out_tdata[3:0], out_tdata[23:4], out_tdata[40:24]);
        fail_count++;
      end else begin
        want = pending_entries.pop_front();
        entries_checked++;
        if (out_tdata[3:0] != want.rank) begin
          $error("rank: expected %0d, got %0d", want.rank, out_tdata[3:0]);
          fail_count++;
        end
        if (out_tdata[23:4] != want.paper) begin
          $error("entry_paper: expected %0h, got %0h", want.paper, out_tdata[23:4]);
          fail_count++;
        end
        if (out_tdata[40:24] != want.score) begin
          $error("score: expected %0d, got %0d", want.score, out_tdata[40:24]);
          fail_count++;
        end
        if (out_tlast != want.last) begin
          $error("last_of_list: expected %0d, got %0d", want.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // Count cycles without any transaction; includes the table load after reset
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    int budget;
    int len;
    int pick;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;

    fill_sig_table();
    vec_len = VLEN_RESET;
    dot_sum = '0;
    for (int k = 0; k < QUERY_DEPTH; k++) begin
      query_mem[k]     = '0;
      query_written[k] = 1'b0;
    end
    for (int k = 0; k < LIST_SIZE; k++) begin
      best_score[k]  = '0;
      best_id[k]     = '0;
      best_filled[k] = 1'b0;
    end

    // Directed rows, run at the reset length of 256
    directed_rows[0]  = mk_row(mk_elem(ACT_FLUSH, 0, 16'h0000, 0), 1'b1, 1'b0, '0);
    directed_rows[1]  = mk_row(mk_elem(ACT_IGNORED, 255, 16'hFFFF, 32'hFFFFF), 1'b0, 1'b0, '0);
    directed_rows[2]  = mk_row(mk_elem(ACT_IGNORED, 0, 16'h0000, 0), 1'b0, 1'b0, '0);
    directed_rows[3]  = mk_row(mk_elem(ACT_LOAD, 0, 16'h7FFF, 0), 1'b0, 1'b0, '0);
    directed_rows[4]  = mk_row(mk_elem(ACT_LOAD, 255, 16'h7FFF, 32'hFFFFF), 1'b0, 1'b0, '0);
    directed_rows[5]  = mk_row(mk_elem(ACT_CAND, 0, 16'h7FFF, 0), 1'b0, 1'b0, '0);
    directed_rows[6]  = mk_row(mk_elem(ACT_CAND, 255, 16'h7FFF, 32'hFFFFF), 1'b0, 1'b0, '0);
    directed_rows[7]  = mk_row(mk_elem(ACT_FLUSH, 0, 16'h0000, 0), 1'b1, 1'b1,
                               {4'd0, 20'hFFFFF, SCORE_ONE, 1'b1});
    directed_rows[8]  = mk_row(mk_elem(ACT_CAND, 0, 16'h8000, 32'h5A5A5), 1'b0, 1'b0, '0);
    directed_rows[9]  = mk_row(mk_elem(ACT_CAND, 255, 16'h8000, 0), 1'b0, 1'b0, '0);
    directed_rows[10] = mk_row(mk_elem(ACT_FLUSH, 0, 16'h0000, 0), 1'b1, 1'b1,
                               {4'd0, 20'h00000, 17'd0, 1'b1});
    // 4.0 * 2.5 sums to exactly +10, which reads the top table entry
    directed_rows[11] = mk_row(mk_elem(ACT_LOAD, 0, 16'h4000, 0), 1'b0, 1'b0, '0);
    directed_rows[12] = mk_row(mk_elem(ACT_CAND, 0, 16'h2800, 0), 1'b0, 1'b0, '0);
    directed_rows[13] = mk_row(mk_elem(ACT_CAND, 255, 16'h0000, 32'h12345), 1'b0, 1'b0, '0);
    directed_rows[14] = mk_row(mk_elem(ACT_FLUSH, 0, 16'h0000, 0), 1'b1, 1'b1,
                               {4'd0, 20'h12345, SCORE_ONE, 1'b1});
    // exactly -10, split by an empty flush that must leave the sum alone
    directed_rows[15] = mk_row(mk_elem(ACT_CAND, 0, 16'hD800, 0), 1'b0, 1'b0, '0);
    directed_rows[16] = mk_row(mk_elem(ACT_FLUSH, 0, 16'h0000, 0), 1'b1, 1'b0, '0);
    directed_rows[17] = mk_row(mk_elem(ACT_CAND, 255, 16'h0000, 32'h54321), 1'b0, 1'b0, '0);
    directed_rows[18] = mk_row(mk_elem(ACT_FLUSH, 0, 16'h0000, 0), 1'b0, 1'b0, '0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_item(directed_rows[i].elem);
      score_and_rank(directed_rows[i].elem, !directed_rows[i].typed);
      if (directed_rows[i].typed && directed_rows[i].has_res)
        pending_entries.push_back(directed_rows[i].res);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      len       = phase_vec[p];
      cfg_we    <= 1'b1;
      cfg_wdata <= VLEN_W'(len);
      @(posedge clk);
      cfg_we    <= 1'b0;
      vec_len   = VLEN_W'(len);
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      budget = items_sent + phase_items[p];

      // load the head of the query and its closing position
      if (len >= 1 && len <= QUERY_DEPTH) begin
        for (int i = 0; i < len && i < 12; i++) issue(mk_elem(ACT_LOAD, i, rand_value(), $urandom));
        issue(mk_elem(ACT_LOAD, len - 1, rand_value(), $urandom));
      end

      while (items_sent < budget) begin
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
          send_candidate(len);
        end else if (pick < 76) begin
          issue(mk_elem(ACT_LOAD, $urandom_range(0, QUERY_DEPTH - 1), rand_value(), $urandom));
        end else if (pick < 84) begin
          issue(mk_elem(ACT_FLUSH, $urandom_range(0, 255), VAL_W'($urandom), $urandom));
        end else if (pick < 90) begin
          issue(mk_elem(ACT_IGNORED, $urandom_range(0, 255), VAL_W'($urandom), $urandom));
        end else begin
          // abandoned or headless candidate fragments
          repeat ($urandom_range(1, 2))
            issue(mk_elem(ACT_CAND, pick_written(0, QUERY_DEPTH - 1), rand_value(), $urandom));
        end
      end
      issue(mk_elem(ACT_FLUSH, 0, VAL_W'($urandom), $urandom));
    end
    wait_drained();

    $display("checked %0d list entries from %0d input transactions", entries_checked, items_sent);
    $display("ran %0d random phases at vector lengths from 1 to 256 and two that never close a vector",
             NUM_PHASES);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
